[src/pulse_width_averaging_counter_assert.svh]
// assertion macros shared by the pulse width averaging counter modules
// expects clk and rst in the scope of each use
`ifndef PULSE_WIDTH_AVERAGING_COUNTER_ASSERT_SVH
`define PULSE_WIDTH_AVERAGING_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PWAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PWAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/pwac_pkg.sv]
// shared types, codes and constants of the pulse width averaging counter
// no dependencies
package pwac_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int RING_DEPTH_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] OP_CAPTURE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [3:0] U_SUM       = 4'd0;
  localparam logic [3:0] U_WIDTH_RAW = 4'd1;
  localparam logic [3:0] U_WIDTH_NS  = 4'd2;
  localparam logic [3:0] U_WIDTH_US  = 4'd3;
  localparam logic [3:0] U_WIDTH_MS  = 4'd4;
  localparam logic [3:0] U_FREQ_S    = 4'd5;
  localparam logic [3:0] U_FREQ_M    = 4'd6;
  localparam logic [3:0] U_FREQ_H    = 4'd7;
  localparam logic [3:0] U_LOW_FIRST = 4'd12;

  localparam logic [1:0] CONV_RAW = 2'd0;
  localparam logic [1:0] CONV_NS  = 2'd1;
  localparam logic [1:0] CONV_US  = 2'd2;
  localparam logic [1:0] CONV_MS  = 2'd3;

  localparam logic [0:0] REG_PRESCALE = 1'd0;
  localparam logic [0:0] REG_AVERAGE  = 1'd1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [31:0] CLOCK_HZ     = 32'd48000000;
  localparam logic [31:0] CLOCK_HZ_MIN = 32'd2880000000;

  // one division job plus its post step
  typedef struct packed {
    logic        ok;
    logic [31:0] num;
    logic [31:0] den;
    logic [3:0]  post_shift;
    logic [9:0]  post_mul;
  } job_t;

endpackage

[src/pwac_if.sv]
// handshake channels of the pulse width averaging counter
// depends on pwac_pkg for nothing but style; plain valid/ready
interface pwac_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  channel_index;
  logic [15:0] capture_value;
  logic        pin_level;
  logic [15:0] timer_now;
  logic [3:0]  unit_code;
  modport source (output valid, operation, channel_index, capture_value, pin_level,
                  timer_now, unit_code, input ready);
  modport sink (input valid, operation, channel_index, capture_value, pin_level,
                timer_now, unit_code, output ready);
endinterface

interface pwac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] query_value;
  logic        query_valid;
  modport source (output valid, query_value, query_valid, input ready);
  modport sink (input valid, query_value, query_valid, output ready);
endinterface

[src/pwac_queue.sv]
// small job queue between front and back
// depends on pwac_pkg
module pwac_queue
  import pwac_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

`include "pulse_width_averaging_counter_assert.svh"
  `PWAC_ASSERT_IMP(a_push_room, push, !full, "push into full queue")
  `PWAC_ASSERT_IMP(a_pop_data, pop, !empty, "pop from empty queue")
  `PWAC_ASSERT_IMP(a_count_max, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "queue count past depth")

endmodule

[src/pwac_front.sv]
// front part: accepts words, keeps channel state and ring memory, builds jobs
// depends on pwac_pkg, pwac_if
module pwac_front
  import pwac_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  pwac_in_if.sink                item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   push,
  output job_t                   push_job,
  input  logic                   full
);
  localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ENTRIES = CHANNELS * RING_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SUM_W   = 16 + $clog2(RING_DEPTH + 1);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_READ = 2'd1;
  localparam logic [1:0] F_EXEC = 2'd2;

  logic [1:0]       fstate;
  logic [3:0]       prescale;
  logic [3:0]       avg;
  logic [7:0]       ovf_count;
  logic [SUM_W-1:0] window_sum [CHANNELS];
  logic [15:0]      prev_cap   [CHANNELS];
  logic [PW-1:0]    ring_pos   [CHANNELS];
  logic [7:0]       ovf_snap   [CHANNELS];
  logic [4:0]       countdown  [CHANNELS];
  logic             last_pin   [CHANNELS];
  logic             ring_valid [ENTRIES];
  logic [15:0]      ring_mem   [ENTRIES];

  // held word
  logic [1:0]  op_q;
  logic [1:0]  ch_q;
  logic [15:0] cap_q;
  logic        pin_q;
  logic [15:0] now_q;
  logic [3:0]  unit_q;
  logic [AW-1:0] addr_q;
  logic [15:0] rd_data;
  logic        rd_ok;

  logic [CW-1:0] ci;
  logic          ch_ok;
  logic          back_sel;
  logic [5:0]    t0, t1, t2;
  logic [PW-1:0] idx;
  logic [AW-1:0] addr;
  logic [3:0]    avg_wr;

  assign ci    = CW'(ch_q);
  assign ch_ok = (int'(ch_q) < CHANNELS);
  assign item.ready = (fstate == F_IDLE);

  // ring slot of the last high or low pulse
  always_comb begin
    back_sel = (unit_q < U_LOW_FIRST) ? last_pin[ci] : !last_pin[ci];
    t0 = 6'(ring_pos[ci]) + 6'(avg) + 6'(avg) - 6'd1 - 6'(back_sel);
    t1 = (t0 >= 6'(avg)) ? t0 - 6'(avg) : t0;
    t2 = (t1 >= 6'(avg)) ? t1 - 6'(avg) : t1;
    idx = (op_q == OP_CAPTURE) ? ring_pos[ci] : PW'(t2);
    addr = AW'(int'(ci) * RING_DEPTH + int'(idx));
    avg_wr = ((cfg_data == 4'd0) || (int'(cfg_data) > RING_DEPTH)) ? 4'd1 : cfg_data;
  end

  // capture arithmetic
  logic [15:0]      delta;
  logic [15:0]      old_delta;
  logic [SUM_W-1:0] sum_next;
  logic [PW-1:0]    pos_next;
  logic             do_cap;

  always_comb begin
    do_cap    = (fstate == F_EXEC) && (op_q == OP_CAPTURE) && ch_ok;
    delta     = cap_q - prev_cap[ci];
    old_delta = rd_ok ? rd_data : 16'd0;
    sum_next  = window_sum[ci] - SUM_W'(old_delta) + SUM_W'(delta);
    pos_next  = (5'(ring_pos[ci]) + 5'd1 == 5'(avg)) ? '0 : ring_pos[ci] + 1'b1;
  end

  // query evaluation
  logic [7:0]  age;
  logic        stale;
  logic [4:0]  cd;
  logic [31:0] sum32, s, raw, mul_in, scaled, avg32;
  logic        is_pulse;

  always_comb begin
    age   = ovf_count - ovf_snap[ci];
    if ((age != 8'd0) && (prev_cap[ci] >= 16'd256) && (now_q < prev_cap[ci] - 16'd256)) begin
      age = age - 8'd1;
    end
    stale    = (age != 8'd0);
    cd       = stale ? 5'(avg) + 5'd1 : countdown[ci];
    sum32    = 32'(window_sum[ci]);
    avg32    = 32'(avg);
    s        = sum32 << prescale;
    raw      = 32'(old_delta) << prescale;
    is_pulse = unit_q[3];
    mul_in   = is_pulse ? raw : s;
    scaled   = mul_in * 32'd250;

    push_job.ok         = ch_ok && (cd == 5'd0);
    push_job.num        = s;
    push_job.den        = 32'd1;
    push_job.post_shift = 4'd0;
    push_job.post_mul   = 10'd1;
    case (unit_q)
      U_SUM: ;
      U_WIDTH_RAW: push_job.den = avg32;
      U_WIDTH_NS: begin
        push_job.num = scaled;
        push_job.den = avg32 * 32'd12;
      end
      U_WIDTH_US: push_job.den = avg32 * 32'd48;
      U_WIDTH_MS: push_job.den = avg32 * 32'd48000;
      U_FREQ_S: begin
        push_job.ok         = push_job.ok && (sum32 != 32'd0);
        push_job.num        = CLOCK_HZ * avg32;
        push_job.den        = sum32;
        push_job.post_shift = prescale;
      end
      U_FREQ_M, U_FREQ_H: begin
        push_job.ok       = push_job.ok && (sum32 != 32'd0);
        push_job.num      = CLOCK_HZ_MIN >> prescale;
        push_job.den      = sum32;
        push_job.post_mul = (unit_q == U_FREQ_M) ? 10'(avg) : 10'(avg) * 10'd60;
      end
      default: begin
        push_job.num = raw;
        case (unit_q[1:0])
          CONV_RAW: ;
          CONV_NS: begin
            push_job.num = scaled;
            push_job.den = 32'd12;
          end
          CONV_US: push_job.den = 32'd48;
          CONV_MS: push_job.den = 32'd48000;
          default: ;
        endcase
      end
    endcase
    push = (fstate == F_EXEC) && (op_q == OP_QUERY) && !full;
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (fstate == F_READ) begin
      rd_data <= ring_mem[addr];
    end
    if (do_cap) begin
      ring_mem[addr_q] <= delta;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      op_q   <= item.operation;
      ch_q   <= item.channel_index;
      cap_q  <= item.capture_value;
      pin_q  <= item.pin_level;
      now_q  <= item.timer_now;
      unit_q <= item.unit_code;
    end
    if (fstate == F_READ) begin
      addr_q <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate    <= F_IDLE;
      prescale  <= '0;
      avg       <= 4'd1;
      ovf_count <= '0;
      rd_ok     <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        window_sum[c] <= '0;
        prev_cap[c]   <= '0;
        ring_pos[c]   <= '0;
        ovf_snap[c]   <= '0;
        countdown[c]  <= 5'd2;
        last_pin[c]   <= 1'b0;
      end
      for (int e = 0; e < ENTRIES; e++) begin
        ring_valid[e] <= 1'b0;
      end
    end else if (cfg_write && (cfg_index == REG_AVERAGE)) begin
      // window change reopens every channel
      avg <= avg_wr;
      for (int c = 0; c < CHANNELS; c++) begin
        window_sum[c] <= '0;
        prev_cap[c]   <= '0;
        ring_pos[c]   <= '0;
        ovf_snap[c]   <= '0;
        countdown[c]  <= 5'(avg_wr) + 5'd1;
        last_pin[c]   <= 1'b0;
      end
      for (int e = 0; e < ENTRIES; e++) begin
        ring_valid[e] <= 1'b0;
      end
    end else begin
      if (cfg_write && (cfg_index == REG_PRESCALE)) begin
        prescale <= cfg_data;
      end
      case (fstate)
        F_IDLE: begin
          if (item.valid) begin
            if (item.operation == OP_TICK) begin
              ovf_count <= ovf_count + 8'd1;
            end else if ((item.operation == OP_CAPTURE) || (item.operation == OP_QUERY)) begin
              fstate <= F_READ;
            end
          end
        end
        F_READ: begin
          rd_ok  <= ring_valid[addr];
          fstate <= F_EXEC;
        end
        F_EXEC: begin
          if (op_q == OP_CAPTURE) begin
            if (ch_ok) begin
              prev_cap[ci]     <= cap_q;
              window_sum[ci]   <= sum_next;
              ring_valid[addr_q] <= 1'b1;
              ring_pos[ci]     <= pos_next;
              ovf_snap[ci]     <= ovf_count;
              last_pin[ci]     <= pin_q;
              if (countdown[ci] != 5'd0) begin
                countdown[ci] <= countdown[ci] - 5'd1;
              end
            end
            fstate <= F_IDLE;
          end else if (!full) begin
            if (ch_ok && stale) begin
              countdown[ci] <= cd;
            end
            fstate <= F_IDLE;
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

endmodule

[src/pwac_back.sv]
// back part: shared restoring divider and post scaling, output register
// depends on pwac_pkg, pwac_if
module pwac_back
  import pwac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  output logic      pop,
  input  job_t      pop_job,
  input  logic      empty,
  pwac_out_if.source result
);
  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_POST = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]  bstate;
  job_t        job;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [4:0]  step;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] shifted;
  logic [31:0] value;
  logic        value_ok;

  assign pop          = (bstate == B_IDLE) && !empty;
  assign rem_sh       = {rem, quo[31]};
  assign ge           = (rem_sh >= {1'b0, job.den});
  assign shifted      = quo >> job.post_shift;
  assign result.valid       = (bstate == B_DONE);
  assign result.query_value = value;
  assign result.query_valid = value_ok;

  always_ff @(posedge clk) begin
    case (bstate)
      B_IDLE: begin
        job  <= pop_job;
        quo  <= pop_job.num;
        rem  <= '0;
        step <= '1;
      end
      B_DIV: begin
        quo  <= {quo[30:0], ge};
        rem  <= ge ? 32'(rem_sh - {1'b0, job.den}) : rem_sh[31:0];
        step <= step - 5'd1;
      end
      B_POST: begin
        value    <= job.ok ? 32'(shifted * 32'(job.post_mul)) : 32'd0;
        value_ok <= job.ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= B_IDLE;
    end else begin
      case (bstate)
        B_IDLE: if (!empty) bstate <= pop_job.ok ? B_DIV : B_POST;
        B_DIV: if (step == 5'd0) bstate <= B_POST;
        B_POST: bstate <= B_DONE;
        B_DONE: if (result.ready) bstate <= B_IDLE;
        default: bstate <= B_IDLE;
      endcase
    end
  end

`include "pulse_width_averaging_counter_assert.svh"
  `PWAC_ASSERT_NXT(a_post_to_done, bstate == B_POST, result.valid, "result not presented")
  `PWAC_ASSERT_NXT(a_hold_value, result.valid && !result.ready, result.valid && $stable(result.query_value), "result changed while stalled")
  `PWAC_ASSERT_IMP(a_div_ok, bstate == B_DIV, job.ok, "division run for a rejected job")

endmodule

[src/pulse_width_averaging_counter.sv]
// top level of the pulse width averaging counter
// depends on pwac_pkg, pwac_if, pwac_front, pwac_queue, pwac_back
//
// usage
//   item channel: one word per operation (capture, overflow tick, query,
//   code 3 is dropped). captures and ticks give no result; each query
//   gives exactly one result word on the result channel.
//   config port: cfg_write with cfg_index 0 sets the prescale shift,
//   index 1 sets the averaging window and reopens every channel.
//   write config only while the block is idle.
// query path
//   ticks and dropped codes are handled at acceptance. captures and
//   queries go through the front's accept, ring memory read and update
//   steps. a query with a valid job then runs through a 32-step restoring
//   divider plus a scaling step; a rejected job skips the divider. the
//   back takes a new job only after its last result has been taken.
// reset
//   synchronous rst clears all channel state, prescale 0, window 1.
// stall
//   a finished result waits in the back's output register; two jobs
//   queue behind it, then a further query stalls the front and holds off new words.
module pulse_width_averaging_counter
  import pwac_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  pwac_in_if.sink                item,
  pwac_out_if.source             result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t pop_job;

  // front: classify words, own the channel state
  pwac_front #(
    .CHANNELS   (CHANNELS),
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  // decouples front and divider
  pwac_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // back: division and scaling into the result register
  pwac_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (empty),
    .result  (result)
  );

endmodule

[tb/sv/testbench.sv]
// self-checking bench for the pulse width averaging counter
// depends on pwac_pkg, pwac_if and the pulse_width_averaging_counter rtl
module testbench;
  import pwac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SETTLE       = 60;
  localparam logic [1:0]  OP_DROPPED   = 2'd3;

  typedef struct {
    logic [31:0] value;
    logic        ok;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  pwac_in_if  item_if ();
  pwac_out_if result_if ();

  pulse_width_averaging_counter dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_if.sink),
    .result    (result_if.source),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the block state
  logic [3:0]  shift_m;
  logic [31:0] window_m;
  logic [31:0] sum_m    [4];
  logic [15:0] ring_m   [4][8];
  logic [15:0] prev_m   [4];
  logic [31:0] pos_m    [4];
  logic [7:0]  snap_m   [4];
  logic [31:0] count_m  [4];
  logic        level_m  [4];
  logic [7:0]  ovf_m;

  answer_t answers_due[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    item_if.valid         = 1'b0;
    item_if.operation     = '0;
    item_if.channel_index = '0;
    item_if.capture_value = '0;
    item_if.pin_level     = 1'b0;
    item_if.timer_now     = '0;
    item_if.unit_code     = '0;
    result_if.ready       = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** pulse_width_averaging_counter: FAILED **");
      $finish;
    end
  end

  // receiver stalls at random in the chosen phases
  always @(posedge clk) begin
    if (rst)
      result_if.ready <= 1'b0;
    else
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result words are sampled mid-cycle, where everything has settled
  always @(negedge clk) begin
    answer_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: result word expected none actual value %h valid %b", $time,
                 result_if.query_value, result_if.query_valid);
      end else begin
        want = answers_due.pop_front();
        if (result_if.query_value !== want.value) begin
          errors++;
          $display("%0t: query_value expected %h actual %h", $time, want.value,
                   result_if.query_value);
        end
        if (result_if.query_valid !== want.ok) begin
          errors++;
          $display("%0t: query_valid expected %b actual %b", $time, want.ok,
                   result_if.query_valid);
        end
      end
    end
  end

  // channel open: resets each channel's mirror, countdown to window + 1; the global overflow count stays
  function automatic void reopen_channels();
    for (int c = 0; c < 4; c++) begin
      sum_m[c]   = '0;
      prev_m[c]  = '0;
      pos_m[c]   = '0;
      snap_m[c]  = '0;
      level_m[c] = 1'b0;
      count_m[c] = window_m + 32'd1;
      for (int i = 0; i < 8; i++) ring_m[c][i] = '0;
    end
  endfunction

  function automatic void reset_mirror();
    shift_m  = '0;
    window_m = 32'd1;
    ovf_m    = '0;
    reopen_channels();
  endfunction

  function automatic void capture_mirror(input logic [1:0] ch, input logic [15:0] cap,
                                         input logic pin);
    logic [15:0] delta;
    logic [31:0] slot;
    delta = cap - prev_m[ch];
    slot = pos_m[ch] % window_m;
    prev_m[ch] = cap;
    sum_m[ch] = sum_m[ch] - {16'd0, ring_m[ch][slot]} + {16'd0, delta};
    ring_m[ch][slot] = delta;
    pos_m[ch] = (slot + 32'd1) % window_m;
    snap_m[ch] = ovf_m;
    if (count_m[ch] != 0) count_m[ch] = count_m[ch] - 32'd1;
    level_m[ch] = pin;
  endfunction

  // measurement in the requested unit, updates the invalid countdown
  function automatic answer_t query_mirror(input logic [1:0] ch, input logic [15:0] now,
                                           input logic [3:0] unit);
    answer_t a;
    logic [7:0]  age;
    logic [31:0] prev, sum, s, raw, idx, back, num;
    a.value = '0;
    a.ok = 1'b0;
    age = ovf_m - snap_m[ch];
    prev = {16'd0, prev_m[ch]};
    // off-by-one correction: overflow after the capture but timer not yet past it
    if (age != 0 && prev >= 32'd256 && {16'd0, now} < prev - 32'd256) age = age - 8'd1;
    if (age != 0) count_m[ch] = window_m + 32'd1;
    if (count_m[ch] != 0) return a;
    sum = sum_m[ch];
    s = sum << shift_m;
    a.ok = 1'b1;
    if (unit == U_SUM) a.value = s;
    else if (unit == U_WIDTH_RAW) a.value = s / window_m;
    else if (unit == U_WIDTH_NS) a.value = s * 32'd250 / 32'd12 / window_m;
    else if (unit == U_WIDTH_US) a.value = s / 32'd48 / window_m;
    else if (unit == U_WIDTH_MS) a.value = s / 32'd48000 / window_m;
    else if (unit == U_FREQ_S || unit == U_FREQ_M || unit == U_FREQ_H) begin
      // zero sum in a frequency unit gives nothing
      if (sum == 0) begin
        a.ok = 1'b0;
        return a;
      end
      if (unit == U_FREQ_S) begin
        num = CLOCK_HZ * window_m;
        a.value = (num / sum) >> shift_m;
      end else begin
        num = CLOCK_HZ_MIN >> shift_m;
        a.value = num / sum * window_m;
        if (unit == U_FREQ_H) a.value = num / sum * 32'd60 * window_m;
      end
    end else begin
      back = (unit < U_LOW_FIRST) ? {31'd0, level_m[ch]} : {31'd0, ~level_m[ch]};
      idx = (pos_m[ch] + 32'd2 * window_m - 32'd1 - back) % window_m;
      raw = {16'd0, ring_m[ch][idx]} << shift_m;
      case (unit[1:0])
        CONV_RAW: a.value = raw;
        CONV_NS:  a.value = raw * 32'd250 / 32'd12;
        CONV_US:  a.value = raw / 32'd48;
        default:  a.value = raw / 32'd48000;
      endcase
    end
    return a;
  endfunction

  // one word on the item channel; called at a rising edge
  task automatic send_word(input logic [1:0] op, input logic [1:0] ch,
                           input logic [15:0] cap, input logic pin,
                           input logic [15:0] now, input logic [3:0] unit);
    bit taken;
    int gap;
    item_if.valid         <= 1'b1;
    item_if.operation     <= op;
    item_if.channel_index <= ch;
    item_if.capture_value <= cap;
    item_if.pin_level     <= pin;
    item_if.timer_now     <= now;
    item_if.unit_code     <= unit;
    do begin
      @(negedge clk);
      taken = item_if.ready;
      @(posedge clk);
    end while (!taken);
    if (op == OP_CAPTURE) capture_mirror(ch, cap, pin);
    else if (op == OP_TICK) ovf_m = ovf_m + 8'd1;
    else if (op == OP_QUERY) answers_due.push_back(query_mirror(ch, now, unit));
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every answer is in
  task automatic hold_until_empty();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // full drain, then the block's own latency for trailing captures
  task automatic drain();
    hold_until_empty();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [3:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_PRESCALE) shift_m = data;
    else begin
      window_m = (data < 4'd1 || data > 4'd8) ? 32'd1 : {28'd0, data};
      reopen_channels();
    end
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // invalid channel right after reset
    send_word(OP_QUERY, 2'd0, 16'd0, 1'b0, 16'd0, U_SUM);
    send_word(OP_CAPTURE, 2'd0, 16'd0, 1'b0, 16'd0, U_SUM);
    send_word(OP_CAPTURE, 2'd0, 16'hffff, 1'b1, 16'd0, U_SUM);
    for (int u = 0; u < 16; u++)
      send_word(OP_QUERY, 2'd0, 16'd0, 1'b0, 16'hffff, u[3:0]);
    // zero delta, frequency of a zero sum
    send_word(OP_CAPTURE, 2'd0, 16'hffff, 1'b0, 16'd0, U_SUM);
    send_word(OP_QUERY, 2'd0, 16'd0, 1'b0, 16'd0, U_FREQ_S);
    // dropped code
    send_word(OP_DROPPED, 2'd3, 16'hffff, 1'b1, 16'hffff, 4'hf);
    // tick covered by the off-by-one correction, then stale without it
    send_word(OP_CAPTURE, 2'd3, 16'h9000, 1'b1, 16'd0, U_SUM);
    send_word(OP_CAPTURE, 2'd3, 16'hf000, 1'b0, 16'd0, U_SUM);
    send_word(OP_TICK, 2'd0, 16'd0, 1'b0, 16'd0, U_SUM);
    send_word(OP_QUERY, 2'd3, 16'd0, 1'b0, 16'h0100, U_WIDTH_RAW);
    send_word(OP_QUERY, 2'd3, 16'd0, 1'b0, 16'hffff, U_WIDTH_RAW);
    send_word(OP_QUERY, 2'd3, 16'd0, 1'b0, 16'h0000, U_WIDTH_RAW);
    drain();
  endtask

  task automatic test_random(input int words, input int idle_pct, input int stall_pct);
    int r;
    logic [1:0]  ch;
    logic [15:0] cap;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < words; i++) begin
      r = $urandom_range(99);
      ch = 2'($urandom_range(3));
      if (i == words / 2) hold_until_empty();
      if (r < 50) begin
        // mostly well-formed pulse trains, sometimes a wild value
        if ($urandom_range(7) == 0) cap = 16'($urandom);
        else cap = prev_m[ch] + 16'($urandom_range(1, 4000));
        send_word(OP_CAPTURE, ch, cap, 1'($urandom), 16'($urandom), 4'($urandom));
      end else if (r < 55) begin
        send_word(OP_TICK, ch, 16'($urandom), 1'($urandom), 16'($urandom), 4'($urandom));
      end else if (r < 58) begin
        send_word(OP_DROPPED, ch, 16'($urandom), 1'($urandom), 16'($urandom),
                  4'($urandom));
      end else begin
        send_word(OP_QUERY, ch, 16'($urandom), 1'($urandom), 16'($urandom),
                  4'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    reset_mirror();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_reg(REG_PRESCALE, 4'd12);
    write_reg(REG_AVERAGE, 4'd8);
    test_random(90, 0, 0);
    write_reg(REG_PRESCALE, 4'd5);
    write_reg(REG_AVERAGE, 4'd3);
    test_random(90, 65, 0);
    write_reg(REG_PRESCALE, 4'd0);
    write_reg(REG_AVERAGE, 4'd0);
    test_random(70, 0, 65);
    write_reg(REG_PRESCALE, 4'd15);
    write_reg(REG_AVERAGE, 4'd9);
    test_random(40, 34, 34);
    write_reg(REG_PRESCALE, 4'd2);
    write_reg(REG_AVERAGE, 4'd15);
    write_reg(REG_AVERAGE, 4'd5);
    test_random(60, 34, 34);
    if (errors == 0 && answers_due.size() == 0)
      $display("** pulse_width_averaging_counter: PASSED **");
    else
      $display("** pulse_width_averaging_counter: FAILED **");
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/pwac_pkg.sv
src/pwac_if.sv
src/pwac_queue.sv
src/pwac_front.sv
src/pwac_back.sv
src/pulse_width_averaging_counter.sv
tb/sv/testbench.sv
